FILE: hw/rtl/stcf_pkg.sv
// Shared constants, types and the font table of the scrolling text column framer.
`default_nettype none

package stcf_pkg;

    // Geometry
    localparam int WINDOW_WIDTH = 10;
    localparam int MAX_CHARS    = 512;
    localparam int GLYPH_COLS   = 5;
    localparam int CHAR_COLS    = 6;

    localparam int IDX_W = $clog2(MAX_CHARS > 1 ? MAX_CHARS : 2);
    localparam int LEN_W = $clog2(MAX_CHARS + 1);
    localparam int OFF_W = $clog2(CHAR_COLS);
    localparam int CNT_W = $clog2(WINDOW_WIDTH > 1 ? WINDOW_WIDTH : 2);

    // Frame delimiters
    localparam logic [7:0] FRAME_HEAD  = 8'h64;
    localparam logic [7:0] FRAME_END   = 8'hC0;
    localparam logic [7:0] BLANK_COL   = 8'h00;

    // Request codes
    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } req_code_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLUMN,
        ST_HEAD,
        ST_BODY,
        ST_TAIL
    } state_t;

    // Message RAM command
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic [IDX_W-1:0] raddr;
    } ram_cmd_t;

    // Window register command
    typedef struct packed {
        logic       clear;
        logic       shift_in;
        logic       rotate;
        logic [7:0] column;
    } win_cmd_t;

    // Five glyph columns, leftmost column in the top byte
    function automatic logic [39:0] font_glyph(input logic [7:0] code);
        logic [39:0] g;
        g = '0;
        unique case (code)
            8'h10: g = 40'hFF_00_00_00_00;
            8'h11: g = 40'hFF_FF_00_00_00;
            8'h12: g = 40'hFF_FF_FF_00_00;
            8'h13: g = 40'hFF_FF_FF_FF_00;
            8'h14: g = 40'hFF_FF_FF_FF_FF;
            8'h15: g = 40'h00_FF_FF_FF_FF;
            8'h16: g = 40'h00_00_FF_FF_FF;
            8'h17: g = 40'h00_00_00_FF_FF;
            8'h18: g = 40'h00_00_00_00_FF;
            8'h19: g = 40'h03_07_7E_20_1C;
            8'h1A: g = 40'h60_66_09_09_09;
            8'h1B: g = 40'h60_6F_0A_0A_08;
            8'h1C: g = 40'h10_18_1C_18_10;
            8'h1D: g = 40'h00_3E_1C_08_00;
            8'h1E: g = 40'h00_08_1C_3E_00;
            8'h1F: g = 40'h04_0C_1C_0C_04;
            8'h21: g = 40'h00_00_79_00_00;
            8'h22: g = 40'h00_70_00_70_00;
            8'h23: g = 40'h14_7F_14_7F_14;
            8'h24: g = 40'h12_2A_7F_2A_24;
            8'h25: g = 40'h62_64_08_13_23;
            8'h26: g = 40'h36_49_55_22_05;
            8'h27: g = 40'h00_50_60_00_00;
            8'h28: g = 40'h00_1C_22_41_00;
            8'h29: g = 40'h00_41_22_1C_00;
            8'h2A: g = 40'h14_08_3E_08_14;
            8'h2B: g = 40'h08_08_3E_08_08;
            8'h30: g = 40'h3E_45_49_51_3E;
            8'h31: g = 40'h00_21_7F_01_00;
            8'h32: g = 40'h21_43_45_49_31;
            8'h33: g = 40'h42_41_51_69_46;
            8'h34: g = 40'h0C_14_24_7F_04;
            8'h35: g = 40'h72_51_51_51_4E;
            8'h36: g = 40'h1E_29_49_49_06;
            8'h37: g = 40'h40_47_48_50_60;
            8'h38: g = 40'h36_49_49_49_36;
            8'h39: g = 40'h30_49_49_4A_3C;
            8'h41: g = 40'h3F_44_44_44_3F;
            8'h42: g = 40'h7F_49_49_49_36;
            8'h43: g = 40'h3E_41_41_41_22;
            8'h44: g = 40'h7F_41_41_22_1C;
            8'h45: g = 40'h7F_49_49_49_41;
            8'h46: g = 40'h7F_48_48_48_40;
            8'h47: g = 40'h3E_41_49_49_2E;
            8'h48: g = 40'h7F_08_08_08_7F;
            8'h49: g = 40'h00_41_7F_41_00;
            8'h4A: g = 40'h02_01_41_7E_40;
            8'h4B: g = 40'h7F_08_14_22_41;
            8'h4C: g = 40'h7F_01_01_01_01;
            8'h4D: g = 40'h7F_20_18_20_7F;
            8'h4E: g = 40'h7F_10_08_04_7F;
            8'h4F: g = 40'h3E_41_41_21_3E;
            8'h50: g = 40'h7F_48_48_48_30;
            8'h51: g = 40'h3E_41_45_42_3D;
            8'h52: g = 40'h7F_48_4C_4A_31;
            8'h53: g = 40'h31_49_49_49_46;
            8'h54: g = 40'h40_40_7F_40_40;
            8'h55: g = 40'h7E_01_01_01_7E;
            8'h56: g = 40'h7C_02_01_02_7C;
            8'h57: g = 40'h7E_01_0E_01_7E;
            8'h58: g = 40'h63_14_08_14_63;
            8'h59: g = 40'h70_08_07_08_70;
            8'h5A: g = 40'h43_45_49_51_61;
            8'h61: g = 40'h02_15_15_15_0F;
            8'h62: g = 40'h7F_05_09_09_06;
            8'h63: g = 40'h0E_11_11_11_02;
            8'h64: g = 40'h06_09_09_05_7F;
            8'h65: g = 40'h0E_15_15_15_0C;
            8'h66: g = 40'h08_3F_48_40_20;
            8'h67: g = 40'h18_25_25_25_3E;
            8'h68: g = 40'h7F_08_10_10_0F;
            8'h69: g = 40'h00_00_2F_00_00;
            8'h6A: g = 40'h02_01_11_5E_00;
            8'h6B: g = 40'h7F_04_0A_11_00;
            8'h6C: g = 40'h00_41_7F_01_00;
            8'h6D: g = 40'h1F_10_0C_10_0F;
            8'h6E: g = 40'h1F_08_10_10_0F;
            8'h6F: g = 40'h0E_11_11_11_0E;
            8'h70: g = 40'h1F_14_14_14_08;
            8'h71: g = 40'h08_14_14_0C_1F;
            8'h72: g = 40'h1F_08_10_10_08;
            8'h73: g = 40'h09_15_15_15_02;
            8'h74: g = 40'h10_7E_11_01_02;
            8'h75: g = 40'h1E_01_01_02_1F;
            8'h76: g = 40'h1C_02_01_02_1C;
            8'h77: g = 40'h1E_01_06_01_1E;
            8'h78: g = 40'h11_0A_04_0A_11;
            8'h79: g = 40'h18_05_05_05_1E;
            8'h7A: g = 40'h11_13_15_19_11;
            8'hFF: g = 40'hFF_FF_FF_FF_FF;
            default: g = '0;
        endcase
        return g;
    endfunction

    // One column of a character cell; the sixth column is the blank spacer
    function automatic logic [7:0] font_column(input logic [7:0] code,
                                               input logic [OFF_W-1:0] off);
        logic [39:0] g;
        logic [7:0]  c;
        g = font_glyph(code);
        c = BLANK_COL;
        unique case (off)
            3'd0:    c = g[39:32];
            3'd1:    c = g[31:24];
            3'd2:    c = g[23:16];
            3'd3:    c = g[15:8];
            3'd4:    c = g[7:0];
            default: c = BLANK_COL;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/stcf_ifs.sv
// Valid/ready channel interfaces for requests and frame bytes.
`default_nettype none

interface stcf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface stcf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/stcf_msg_ram.sv
// Message character store: one write port, one registered read port.
`default_nettype none

module stcf_msg_ram (
    input  wire logic               clk,
    input  wire stcf_pkg::ram_cmd_t cmd,
    output logic [7:0]              rd_data
);

    logic [7:0] mem [stcf_pkg::MAX_CHARS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[cmd.raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stcf_window.sv
// Display window: column shift register that also rotates to stream its bytes.
`default_nettype none

module stcf_window (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stcf_pkg::win_cmd_t cmd,
    output logic [7:0]              head
);

    logic [7:0] win_reg  [stcf_pkg::WINDOW_WIDTH];
    logic [7:0] win_next [stcf_pkg::WINDOW_WIDTH];

    // Clear to blank columns, shift in a new column, or rotate the leftmost column to the right end
    always_comb
    begin
        for (int j = 0; j < stcf_pkg::WINDOW_WIDTH; j++)
        begin
            win_next[j] = win_reg[j];
        end
        if (cmd.clear)
        begin
            for (int j = 0; j < stcf_pkg::WINDOW_WIDTH; j++)
            begin
                win_next[j] = stcf_pkg::BLANK_COL;
            end
        end
        else if (cmd.shift_in || cmd.rotate)
        begin
            for (int j = 0; j + 1 < stcf_pkg::WINDOW_WIDTH; j++)
            begin
                win_next[j] = win_reg[j + 1];
            end
            win_next[stcf_pkg::WINDOW_WIDTH - 1] = cmd.shift_in ? cmd.column : win_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < stcf_pkg::WINDOW_WIDTH; j++)
            begin
                win_reg[j] <= stcf_pkg::BLANK_COL;
            end
        end
        else
        begin
            for (int j = 0; j < stcf_pkg::WINDOW_WIDTH; j++)
            begin
                win_reg[j] <= win_next[j];
            end
        end
    end

    assign head = win_reg[0];

endmodule

`default_nettype wire

FILE: hw/rtl/stcf_ctrl.sv
// Sequencer: request decode, scroll position, column fetch and frame emission.
`default_nettype none

module stcf_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    stcf_req_if.sink                req,
    stcf_frame_if.source            frame,
    input  wire logic [7:0]         rd_data,
    input  wire logic [7:0]         win_head,
    output stcf_pkg::ram_cmd_t      ram_cmd,
    output stcf_pkg::win_cmd_t      win_cmd
);

    stcf_pkg::state_t                state_reg, state_next;
    logic [stcf_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [stcf_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [stcf_pkg::OFF_W-1:0]      off_reg, off_next;
    logic [stcf_pkg::CNT_W-1:0]      cnt_reg, cnt_next;

    logic accept;
    logic full;
    logic last_col;
    logic body_done;

    assign accept    = req.valid && req.ready;
    assign full      = (len_reg == stcf_pkg::LEN_W'(stcf_pkg::MAX_CHARS));
    assign last_col  = (off_reg == stcf_pkg::OFF_W'(stcf_pkg::CHAR_COLS - 1)) &&
                       ((stcf_pkg::LEN_W'(idx_reg) + stcf_pkg::LEN_W'(1)) == len_reg);
    assign body_done = (cnt_reg == stcf_pkg::CNT_W'(stcf_pkg::WINDOW_WIDTH - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stcf_pkg::ST_IDLE:
            begin
                if (accept && req.req_type == stcf_pkg::REQ_TICK)
                begin
                    state_next = stcf_pkg::ST_COLUMN;
                end
            end
            stcf_pkg::ST_COLUMN: state_next = stcf_pkg::ST_HEAD;
            stcf_pkg::ST_HEAD:
            begin
                if (frame.ready)
                begin
                    state_next = stcf_pkg::ST_BODY;
                end
            end
            stcf_pkg::ST_BODY:
            begin
                if (frame.ready && body_done)
                begin
                    state_next = stcf_pkg::ST_TAIL;
                end
            end
            stcf_pkg::ST_TAIL:
            begin
                if (frame.ready)
                begin
                    state_next = stcf_pkg::ST_IDLE;
                end
            end
            default: state_next = stcf_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        req.ready        = 1'b0;
        frame.valid      = 1'b0;
        frame.frame_byte = stcf_pkg::BLANK_COL;
        frame.frame_last = 1'b0;
        win_cmd.clear    = 1'b0;
        win_cmd.shift_in = 1'b0;
        win_cmd.rotate   = 1'b0;
        win_cmd.column   = (len_reg == '0) ? stcf_pkg::BLANK_COL
                                           : stcf_pkg::font_column(rd_data, off_reg);
        ram_cmd.we       = 1'b0;
        ram_cmd.waddr    = len_reg[stcf_pkg::IDX_W-1:0];
        ram_cmd.wdata    = req.char_code;
        ram_cmd.raddr    = idx_reg;
        unique case (state_reg)
            stcf_pkg::ST_IDLE:
            begin
                req.ready     = 1'b1;
                win_cmd.clear = accept && (req.req_type == stcf_pkg::REQ_START);
                ram_cmd.we    = accept && (req.req_type == stcf_pkg::REQ_APPEND) && !full;
            end
            stcf_pkg::ST_COLUMN:
            begin
                win_cmd.shift_in = 1'b1;
            end
            stcf_pkg::ST_HEAD:
            begin
                frame.valid      = 1'b1;
                frame.frame_byte = stcf_pkg::FRAME_HEAD;
            end
            stcf_pkg::ST_BODY:
            begin
                frame.valid      = 1'b1;
                frame.frame_byte = win_head;
                win_cmd.rotate   = frame.ready;
            end
            stcf_pkg::ST_TAIL:
            begin
                frame.valid      = 1'b1;
                frame.frame_byte = stcf_pkg::FRAME_END;
                frame.frame_last = 1'b1;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Message length, scroll position and byte counter
    always_comb
    begin
        len_next = len_reg;
        idx_next = idx_reg;
        off_next = off_reg;
        cnt_next = cnt_reg;
        if (accept && req.req_type == stcf_pkg::REQ_START)
        begin
            len_next = '0;
            idx_next = '0;
            off_next = '0;
        end
        else if (accept && req.req_type == stcf_pkg::REQ_APPEND && !full)
        begin
            len_next = len_reg + stcf_pkg::LEN_W'(1);
        end
        if (state_reg == stcf_pkg::ST_COLUMN)
        begin
            cnt_next = '0;
            // Empty message holds at zero; otherwise step and wrap at the end
            if (len_reg == '0 || last_col)
            begin
                idx_next = '0;
                off_next = '0;
            end
            else if (off_reg == stcf_pkg::OFF_W'(stcf_pkg::CHAR_COLS - 1))
            begin
                idx_next = idx_reg + stcf_pkg::IDX_W'(1);
                off_next = '0;
            end
            else
            begin
                off_next = off_reg + stcf_pkg::OFF_W'(1);
            end
        end
        if (state_reg == stcf_pkg::ST_BODY && frame.ready)
        begin
            cnt_next = cnt_reg + stcf_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stcf_pkg::ST_IDLE;
            len_reg   <= '0;
            idx_reg   <= '0;
            off_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            off_reg   <= off_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/scrolling_text_column_framer.sv
// Start and append complete in the cycle they transfer. A tick first shifts the next
// column into the window in the column state, then puts the frame head out.
// Throughput: no new request is taken until a tick's frame end transfers; the frame
// streams one byte per cycle from the rotating window while frame.ready is high.
// Reset: length, scroll position, window and sequencer clear at once; the message
// RAM is not cleared and entries are read only after being written.
`default_nettype none

module scrolling_text_column_framer (
    input  wire logic    clk,
    input  wire logic    rst_n,
    stcf_req_if.sink     req,
    stcf_frame_if.source frame
);

    stcf_pkg::ram_cmd_t ram_cmd;
    stcf_pkg::win_cmd_t win_cmd;
    logic [7:0]         rd_data;
    logic [7:0]         win_head;

    // Sequencer
    stcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .frame    (frame),
        .rd_data  (rd_data),
        .win_head (win_head),
        .ram_cmd  (ram_cmd),
        .win_cmd  (win_cmd)
    );

    // Message store
    stcf_msg_ram u_ram (
        .clk     (clk),
        .cmd     (ram_cmd),
        .rd_data (rd_data)
    );

    // Window columns
    stcf_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (win_cmd),
        .head  (win_head)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/stcf_checker.sv
// Port-level checks of the framer's sequencing, bound to the top level.
`default_nettype none

module stcf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic [1:0] req_type,
    input wire logic       frame_valid,
    input wire logic       frame_ready,
    input wire logic [7:0] frame_byte,
    input wire logic       frame_last
);

    // No request is taken while a frame is in flight
    a_busy_while_framing: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> !req_ready)
        else $error("request ready while frame bytes pending");

    // A tick is followed by a frame that opens with the head byte
    a_tick_head: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_type == stcf_pkg::REQ_TICK) |->
        ##2 (frame_valid && frame_byte == stcf_pkg::FRAME_HEAD && !frame_last))
        else $error("tick did not open a frame");

    // The closing byte is always the end marker
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_last) |-> (frame_byte == stcf_pkg::FRAME_END))
        else $error("frame_last on a byte other than the end marker");

    // After the closing transfer the block is idle again
    a_idle_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame_ready && frame_last) |=> (req_ready && !frame_valid))
        else $error("block not idle after frame end");

    // Requests other than a tick produce no frame
    a_no_frame_otherwise: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_type != stcf_pkg::REQ_TICK) |=>
        (req_ready && !frame_valid))
        else $error("non-tick request started a frame");

endmodule

bind scrolling_text_column_framer stcf_checker u_stcf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_type    (req.req_type),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_byte  (frame.frame_byte),
    .frame_last  (frame.frame_last)
);

`default_nettype wire
